// ===== design/lbf_pkg.sv =====
// Shared types and constants for the breathing LED fader.
package lbf_pkg;

    // Input transaction: event kind and its millisecond timestamp
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
    } t_in_item;

    // Output transaction: one RGBW color and the ended flag
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_white;
        logic       is_ended;
    } t_out_item;

    // Event kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2,
        KIND_KILL  = 2'd3
    } t_kind;

    // Envelope phase
    typedef enum logic [1:0] {
        PH_STARTING = 2'd0,
        PH_RUNNING  = 2'd1,
        PH_ENDING   = 2'd2,
        PH_ENDED    = 2'd3
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_D,
        S_POST,
        S_MUL,
        S_DIV_CH,
        S_DONE
    } t_state;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASE_RED   = 3'd0;
    localparam logic [2:0] CFG_BASE_GREEN = 3'd1;
    localparam logic [2:0] CFG_BASE_BLUE  = 3'd2;
    localparam logic [2:0] CFG_BASE_WHITE = 3'd3;
    localparam logic [2:0] CFG_HALF_PER   = 3'd4;
    localparam logic [2:0] CFG_FIRST_LED  = 3'd5;
    localparam logic [2:0] CFG_LAST_LED   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] HALF_PER_RESET = 16'd1000;
    localparam int          NUM_CHAN       = 4;

endpackage

// ===== design/led_breathing_fader.sv =====
// Breathing LED fader: triangle-wave RGBW envelope driven by timestamped events.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries events: tick,
//   start, request end and kill, each with a millisecond timestamp. Only a
//   tick produces an output transaction (o_out_valid / i_out_stall /
//   o_out_data): four channel values and an ended flag.
//   Start and kill complete in the accept cycle. An end request in the
//   running phase runs a 32-step divide plus a fix-up of the origin.
//   A tick that needs a color uses one shared restoring divider: it runs
//   32 steps for elapsed time / half period, then each of the four
//   channels takes a multiply and 8 divide steps. A dark tick (ended,
//   or the end of a fading breath) goes straight to the done state.
//   The input is stalled while an event is being worked on; one finished
//   result may wait in the output register while the next event is accepted.
//   If the receiver stalls and a second result is ready, the block holds it
//   internally and keeps the input stalled until the output register frees.
//   LED range registers are write-only and do not affect the color values.
//   Reset (synchronous, active low) puts the envelope in the ended phase,
//   clears the origin time and peaks, and sets the half period to 1000 ms.
module led_breathing_fader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lbf_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lbf_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [lbf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lbf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lbf_pkg::*;

    // Configuration registers
    logic [NUM_CHAN-1:0][7:0] r_base;
    logic [15:0]              r_half;

    // Control and datapath registers
    t_state                   r_state, n_state;
    t_phase                   r_phase, n_phase;
    logic [31:0]              r_origin, n_origin;
    logic [31:0]              r_now, n_now;
    logic                     r_is_end, n_is_end;
    logic [15:0]              r_rem, n_rem;
    logic [31:0]              r_quo, n_quo;
    logic [4:0]               r_cnt, n_cnt;
    logic [15:0]              r_num, n_num;
    logic [1:0]               r_ch, n_ch;
    logic [NUM_CHAN-1:0][7:0] r_chan, n_chan;
    logic                     r_ended, n_ended;
    t_out_item                r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic [15:0] eff_p;
    logic [16:0] two_p;
    logic [31:0] d_now;
    logic        accept;
    logic        fade_done;
    logic        out_free;
    logic [16:0] step_cat;
    logic [17:0] step_diff;
    logic        step_ge;
    logic [15:0] step_rem;
    logic [31:0] step_quo;
    logic [23:0] prod;
    logic        even_slope;

    // Common terms
    assign eff_p     = (r_half == 16'd0) ? 16'd1 : r_half;
    assign two_p     = {eff_p, 1'b0};
    assign d_now     = i_in_data.now_ms - r_origin;
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign fade_done = d_now >= {15'd0, two_p};
    assign out_free  = !r_out_valid || !i_out_stall;
    assign even_slope = ~r_quo[0];

    // Shared restoring divider step
    assign step_cat  = {r_rem, r_quo[31]};
    assign step_diff = {1'b0, step_cat} - {2'b00, eff_p};
    assign step_ge   = ~step_diff[17];
    assign step_rem  = step_ge ? step_diff[15:0] : step_cat[15:0];
    assign step_quo  = {r_quo[30:0], step_ge};

    // Peak times slope position, registered before the channel divide
    assign prod = {16'd0, r_base[r_ch]} * {8'd0, r_num};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_in_data.kind))
                        KIND_TICK: begin
                            unique case (r_phase)
                                PH_STARTING, PH_RUNNING: n_state = S_DIV_D;
                                PH_ENDING: n_state = fade_done ? S_DONE : S_DIV_D;
                                PH_ENDED:  n_state = S_DONE;
                                default:   n_state = S_DONE;
                            endcase
                        end
                        KIND_END: begin
                            if (r_phase == PH_RUNNING) begin
                                n_state = S_DIV_D;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV_D: begin
                if (r_cnt == 5'd0) begin
                    n_state = S_POST;
                end
            end
            S_POST:   n_state = r_is_end ? S_IDLE : S_MUL;
            S_MUL:    n_state = S_DIV_CH;
            S_DIV_CH: begin
                if (r_cnt == 5'd0) begin
                    n_state = (r_ch == 2'(NUM_CHAN - 1)) ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb begin
        n_phase     = r_phase;
        n_origin    = r_origin;
        n_now       = r_now;
        n_is_end    = r_is_end;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_ch        = r_ch;
        n_chan      = r_chan;
        n_ended     = r_ended;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now    = i_in_data.now_ms;
                    n_ch     = 2'd0;
                    n_is_end = 1'b0;
                    n_rem    = 16'd0;
                    n_quo    = d_now;
                    // step counter is loaded only when the divider runs
                    if (n_state == S_DIV_D) begin
                        n_cnt = 5'd31;
                    end
                    unique case (t_kind'(i_in_data.kind))
                        KIND_START: n_phase = PH_STARTING;
                        KIND_KILL:  n_phase = PH_ENDED;
                        KIND_END: begin
                            if (r_phase == PH_STARTING) begin
                                n_phase = PH_ENDED;
                            end
                            n_is_end = 1'b1;
                        end
                        KIND_TICK: begin
                            n_ended = 1'b0;
                            unique case (r_phase)
                                PH_STARTING: begin
                                    // first tick: envelope starts here, dark
                                    n_origin = i_in_data.now_ms;
                                    n_phase  = PH_RUNNING;
                                    n_quo    = 32'd0;
                                end
                                PH_RUNNING: ;
                                PH_ENDING: begin
                                    if (fade_done) begin
                                        n_phase = PH_ENDED;
                                        n_chan  = '0;
                                        n_ended = 1'b1;
                                    end
                                end
                                default: begin
                                    n_chan  = '0;
                                    n_ended = 1'b1;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV_D: begin
                n_rem = step_rem;
                n_quo = step_quo;
                if (r_cnt != 5'd0) begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_POST: begin
                if (r_is_end) begin
                    // move origin to the falling point of equal brightness
                    if (even_slope) begin
                        n_origin = r_now - ({15'd0, two_p} - {16'd0, r_rem});
                    end else begin
                        n_origin = r_now - ({16'd0, eff_p} + {16'd0, r_rem});
                    end
                    n_phase = PH_ENDING;
                end else begin
                    n_num = even_slope ? r_rem : (eff_p - r_rem);
                end
            end
            S_MUL: begin
                // quotient fits in 8 bits, so the top 16 bits start as remainder
                n_rem = prod[23:8];
                n_quo = {prod[7:0], 24'd0};
                n_cnt = 5'd7;
            end
            S_DIV_CH: begin
                n_rem = step_rem;
                n_quo = step_quo;
                if (r_cnt != 5'd0) begin
                    n_cnt = r_cnt - 5'd1;
                end else begin
                    n_chan[r_ch] = step_quo[7:0];
                    n_ch         = r_ch + 2'd1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.out_red   = r_chan[0];
                    n_out.out_green = r_chan[1];
                    n_out.out_blue  = r_chan[2];
                    n_out.out_white = r_chan[3];
                    n_out.is_ended  = r_ended;
                    n_out_valid     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ENDED;
            r_origin    <= 32'd0;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_origin    <= n_origin;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_now    <= n_now;
        r_is_end <= n_is_end;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_num    <= n_num;
        r_ch     <= n_ch;
        r_chan   <= n_chan;
        r_ended  <= n_ended;
        r_out    <= n_out;
    end

    // Configuration writes; LED range indexes are accepted and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_half <= HALF_PER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_RED:   r_base[0] <= i_cfg_data[7:0];
                CFG_BASE_GREEN: r_base[1] <= i_cfg_data[7:0];
                CFG_BASE_BLUE:  r_base[2] <= i_cfg_data[7:0];
                CFG_BASE_WHITE: r_base[3] <= i_cfg_data[7:0];
                CFG_HALF_PER:   r_half    <= i_cfg_data;
                CFG_FIRST_LED, CFG_LAST_LED: ;
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Step counter only runs inside the divide states
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV_D && r_state != S_DIV_CH) |-> (r_cnt == 5'd0))
        else $error("step counter active outside divide");

    // Partial remainder always stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_D || r_state == S_DIV_CH) |-> (r_rem < eff_p))
        else $error("divider remainder out of range");

    // An ended result is always dark
    a_ended_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_ended) |->
        (o_out_data.out_red == 8'd0 && o_out_data.out_green == 8'd0 &&
         o_out_data.out_blue == 8'd0 && o_out_data.out_white == 8'd0))
        else $error("ended result carries color");

    // A new result only comes from the done state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule
